// File: rtl/rir_pkg.sv
`default_nettype none
package rir_pkg;

	// field and register widths
	localparam int CFGW     = 9;
	localparam int CFG_IDXW = 3;
	localparam int COORDW   = 8;
	localparam int CHW      = 8;
	localparam int PIXW     = 3 * CHW;
	localparam int NUM_CH   = 3;
	localparam int NUM_SAMP = 4;

	// 1.16 weights
	localparam int FRACW = 16;
	localparam int WTW   = FRACW + 1;
	localparam int WW    = 2 * FRACW + 1;
	localparam logic [WTW-1:0] ONE_FX = WTW'(1) << FRACW;

	// item commands
	localparam logic CMD_LOAD    = 1'b0;
	localparam logic CMD_COMPUTE = 1'b1;

	// register indexes
	localparam logic [CFG_IDXW-1:0] REG_SRC_W = 3'd0;
	localparam logic [CFG_IDXW-1:0] REG_SRC_H = 3'd1;
	localparam logic [CFG_IDXW-1:0] REG_DST_W = 3'd2;
	localparam logic [CFG_IDXW-1:0] REG_DST_H = 3'd3;

	// bilinear sample slots
	localparam int SAMP_A = 0;
	localparam int SAMP_B = 1;
	localparam int SAMP_C = 2;
	localparam int SAMP_D = 3;

	typedef struct packed {
		logic                clr;
		logic [NUM_SAMP-1:0] samp_we;
		logic                prod_en;
		logic                acc_en;
		logic                avg_we;
	} rir_lane_ctl_t;

endpackage
`default_nettype wire

// File: rtl/rir_in_if.sv
`default_nettype none
interface rir_in_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] pos_x;
	logic [7:0] pos_y;
	logic [7:0] in_red;
	logic [7:0] in_green;
	logic [7:0] in_blue;

	modport source (output valid, command, pos_x, pos_y, in_red, in_green, in_blue,
		input ready);
	modport sink (input valid, command, pos_x, pos_y, in_red, in_green, in_blue,
		output ready);
endinterface
`default_nettype wire

// File: rtl/rir_out_if.sv
`default_nettype none
interface rir_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_x;
	logic [7:0] out_y;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;

	modport source (output valid, out_x, out_y, out_red, out_green, out_blue, input ready);
	modport sink (input valid, out_x, out_y, out_red, out_green, out_blue, output ready);
endinterface
`default_nettype wire

// File: rtl/rir_cfg_if.sv
`default_nettype none
interface rir_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] index;
	logic [8:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/rir_ram.sv
`default_nettype none
module rir_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: rtl/rir_div.sv
`default_nettype none
module rir_div #(
	parameter int W = 59
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] num,
	input  wire logic [W-1:0] den,
	output logic              busy,
	output logic              done,
	output logic      [W-1:0] quo
);
	localparam int CNTW = $clog2(W + 1);

	logic [W:0]      rem_q;
	logic [W-1:0]    num_q;
	logic [W-1:0]    den_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [W:0]      rem_sh;
	logic            ge;

	// one quotient bit a cycle, restoring
	always_comb begin
		rem_sh = {rem_q[W-1:0], num_q[W-1]};
		ge     = rem_sh >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
			num_q <= {num_q[W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = num_q;
endmodule
`default_nettype wire

// File: rtl/rir_lane.sv
`default_nettype none
module rir_lane #(
	parameter int ACCW = 57
) (
	input  wire logic                   clk,
	input  wire rir_pkg::rir_lane_ctl_t ctl,
	input  wire logic [7:0]             pix,
	input  wire logic [32:0]            w_s1,
	input  wire logic [7:0]             avg,
	input  wire logic [15:0]            ab,
	input  wire logic [15:0]            ac,
	output logic      [ACCW-1:0]        acc,
	output logic      [7:0]             res
);
	import rir_pkg::*;

	logic [CHW-1:0]      samp_q [NUM_SAMP];
	logic [WW+CHW-1:0]   prod_s2;
	logic [ACCW-1:0]     acc_q;
	logic [CHW+WTW-1:0]  top_s1;
	logic [CHW+WTW-1:0]  bot_s1;
	logic [CHW+2*WTW-1:0] all_s2;
	logic [WTW-1:0]      nab;
	logic [WTW-1:0]      nac;

	assign nab = ONE_FX - WTW'(ab);
	assign nac = ONE_FX - WTW'(ac);

	// capture samples, overwrite the first with the box average
	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_SAMP; k++) begin
			if (ctl.clr) begin
				samp_q[k] <= '0;
			end else if (ctl.samp_we[k]) begin
				samp_q[k] <= pix;
			end
		end
		if (ctl.avg_we) begin
			samp_q[SAMP_A] <= avg;
		end
	end

	// weighted sum over the box window
	always_ff @(posedge clk) begin
		if (ctl.prod_en) begin
			prod_s2 <= (WW+CHW)'(w_s1) * (WW+CHW)'(pix);
		end
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (ctl.acc_en) begin
			acc_q <= acc_q + ACCW'(prod_s2);
		end
	end

	// blend along x, then along y
	always_ff @(posedge clk) begin
		top_s1 <= (CHW+WTW)'(nab) * (CHW+WTW)'(samp_q[SAMP_A])
			+ (CHW+WTW)'(ab) * (CHW+WTW)'(samp_q[SAMP_B]);
		bot_s1 <= (CHW+WTW)'(nab) * (CHW+WTW)'(samp_q[SAMP_C])
			+ (CHW+WTW)'(ab) * (CHW+WTW)'(samp_q[SAMP_D]);
		all_s2 <= (CHW+2*WTW)'(nac) * (CHW+2*WTW)'(top_s1)
			+ (CHW+2*WTW)'(ac) * (CHW+2*WTW)'(bot_s1);
	end

	assign acc = acc_q;
	assign res = all_s2[2*FRACW +: CHW];
endmodule
`default_nettype wire

// File: rtl/rgb_image_resampler.sv
`default_nettype none
// RGB frame resampler. A load item (command 0) writes one pixel into the source frame
// store; coordinates outside the store are dropped. A compute item (command 1) returns
// one pixel of the destination image. It uses the shared restoring divider, which
// produces one quotient bit a cycle, for two position divisions when neither axis
// shrinks, six when one does; then come four source reads, and when shrinking a walk
// over the covered source window at one pixel a cycle, followed by three averaging
// divisions, one per color lane; then blending and output. The three color lanes work
// side by side. The source frame has no reset; reading a pixel that was never loaded
// gives any value.
module rgb_image_resampler #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input wire logic clk,
	input wire logic arst_n,
	rir_in_if.sink   in_ch,
	rir_out_if.source out_ch,
	rir_cfg_if.sink  cfg_ch
);
	import rir_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int CXW   = $clog2(MAX_WIDTH);
	localparam int CYW   = $clog2(MAX_HEIGHT);
	localparam int PXW   = $clog2(MAX_WIDTH + 1) + FRACW;
	localparam int PYW   = $clog2(MAX_HEIGHT + 1) + FRACW;
	localparam int ACCW  = WW + CHW + AW;
	localparam int TOTW  = WW + AW;
	localparam int NUMW  = ACCW + 2;

	localparam logic [3:0] DSEL_FX   = 4'd0;
	localparam logic [3:0] DSEL_FY   = 4'd1;
	localparam logic [3:0] DSEL_P1X  = 4'd2;
	localparam logic [3:0] DSEL_P2X  = 4'd3;
	localparam logic [3:0] DSEL_P1Y  = 4'd4;
	localparam logic [3:0] DSEL_P2Y  = 4'd5;
	localparam logic [3:0] DSEL_AVG0 = 4'd6;
	localparam logic [3:0] DSEL_AVG1 = 4'd7;
	localparam logic [3:0] DSEL_AVG2 = 4'd8;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_DIV   = 7'b0000010,
		ST_SAMP  = 7'b0000100,
		ST_BOX   = 7'b0001000,
		ST_AVG   = 7'b0010000,
		ST_BLEND = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	function automatic logic [CFGW-1:0] clamp_size(input logic [CFGW-1:0] v, input int maxv);
		logic [CFGW-1:0] r;
		r = v;
		if (v == '0) begin
			r = CFGW'(1);
		end else if (int'(v) > maxv) begin
			r = CFGW'(maxv);
		end
		return r;
	endfunction

	state_t            state_q;
	logic [CFGW-1:0]   src_w_q, src_h_q, dst_w_q, dst_h_q;
	logic [COORDW-1:0] px_q, py_q, i_q, j_q;
	logic              shr_x_q, shr_y_q;
	logic [3:0]        sel_q;
	logic              launch_q;
	logic [PXW-1:0]    fx_q, p1x_q, p2x_q;
	logic [PYW-1:0]    fy_q, p1y_q, p2y_q;
	logic [2:0]        samp_q;
	logic [NUM_SAMP-1:0] samp_we_s1;
	logic [CXW-1:0]    u_q;
	logic [CYW-1:0]    v_q;
	logic              box_done_q;
	logic              v_s1, v_s2;
	logic [WW-1:0]     w_s1;
	logic [TOTW-1:0]   tot_q;
	logic              blend_q;
	logic              out_valid_q;
	logic [COORDW-1:0] out_x_q, out_y_q;
	logic [CHW-1:0]    out_r_q, out_g_q, out_b_q;

	logic              in_acc, cmp_acc, ram_we, out_load;
	logic [AW-1:0]     waddr, raddr;
	logic [PIXW-1:0]   rdata;
	logic              div_start, div_busy, div_done;
	logic [NUMW-1:0]   div_num, div_den, div_quo;
	logic [COORDW-1:0] i_in, j_in;
	logic              shrink;

	logic [CFGW+COORDW-1:0] m_lx, m_ly, m_bx1, m_by1, m_bx2, m_by2;

	logic [CXW-1:0]    oi, oi2, x0, xl, bx;
	logic [CYW-1:0]    oj, oj2, y0, yl, by;
	logic [15:0]       ab, ac;
	logic [NUM_SAMP-1:0] need;
	logic [PXW-FRACW-1:0] ex;
	logic [PYW-FRACW-1:0] ey;
	logic [WTW-1:0]    w1x, w2x, w1y, w2y, wx, wy;
	logic              box_issue, samp_issue;
	logic [ACCW-1:0]   lane_acc [NUM_CH];
	logic [CHW-1:0]    lane_res [NUM_CH];
	rir_lane_ctl_t     lane_ctl [NUM_CH];
	logic [ACCW-1:0]   avg_acc;

	assign in_acc  = in_ch.valid && in_ch.ready;
	assign cmp_acc = in_acc && (in_ch.command == CMD_COMPUTE);
	assign ram_we  = in_acc && (in_ch.command == CMD_LOAD)
		&& (int'(in_ch.pos_x) < MAX_WIDTH) && (int'(in_ch.pos_y) < MAX_HEIGHT);
	assign waddr   = AW'(in_ch.pos_y) * AW'(MAX_WIDTH) + AW'(in_ch.pos_x);
	assign in_ch.ready  = (state_q == ST_IDLE);
	assign cfg_ch.ready = 1'b1;
	assign shrink  = shr_x_q || shr_y_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= CFGW'(1);
			src_h_q <= CFGW'(1);
			dst_w_q <= CFGW'(1);
			dst_h_q <= CFGW'(1);
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				REG_SRC_W: src_w_q <= clamp_size(cfg_ch.data, MAX_WIDTH);
				REG_SRC_H: src_h_q <= clamp_size(cfg_ch.data, MAX_HEIGHT);
				REG_DST_W: dst_w_q <= clamp_size(cfg_ch.data, MAX_WIDTH);
				REG_DST_H: dst_h_q <= clamp_size(cfg_ch.data, MAX_HEIGHT);
				default: ;
			endcase
		end
	end

	// clamp the destination coordinate into the target
	assign i_in = (CFGW'(in_ch.pos_x) < dst_w_q) ? in_ch.pos_x : COORDW'(dst_w_q - 1'b1);
	assign j_in = (CFGW'(in_ch.pos_y) < dst_h_q) ? in_ch.pos_y : COORDW'(dst_h_q - 1'b1);

	// divider operands
	always_comb begin
		m_lx  = (src_w_q - 1'b1) * i_q;
		m_ly  = (src_h_q - 1'b1) * j_q;
		m_bx1 = src_w_q * i_q;
		m_by1 = src_h_q * j_q;
		m_bx2 = src_w_q * (CFGW'(i_q) + 1'b1);
		m_by2 = src_h_q * (CFGW'(j_q) + 1'b1);
		case (sel_q)
			DSEL_AVG0: avg_acc = lane_acc[0];
			DSEL_AVG1: avg_acc = lane_acc[1];
			default:   avg_acc = lane_acc[2];
		endcase
		div_num = '0;
		div_den = NUMW'(1);
		case (sel_q)
			DSEL_FX: begin
				if (dst_w_q > CFGW'(1)) begin
					div_num = NUMW'(m_lx) << FRACW;
					div_den = NUMW'(dst_w_q - 1'b1);
				end
			end
			DSEL_FY: begin
				if (dst_h_q > CFGW'(1)) begin
					div_num = NUMW'(m_ly) << FRACW;
					div_den = NUMW'(dst_h_q - 1'b1);
				end
			end
			DSEL_P1X: begin
				div_num = NUMW'(m_bx1) << FRACW;
				div_den = NUMW'(dst_w_q);
			end
			DSEL_P2X: begin
				div_num = NUMW'(m_bx2) << FRACW;
				div_den = NUMW'(dst_w_q);
			end
			DSEL_P1Y: begin
				div_num = NUMW'(m_by1) << FRACW;
				div_den = NUMW'(dst_h_q);
			end
			DSEL_P2Y: begin
				div_num = NUMW'(m_by2) << FRACW;
				div_den = NUMW'(dst_h_q);
			end
			DSEL_AVG0, DSEL_AVG1, DSEL_AVG2: begin
				div_num = {1'b0, avg_acc, 1'b0} + NUMW'(tot_q) - 1'b1;
				div_den = NUMW'({tot_q, 1'b0});
			end
			default: ;
		endcase
	end

	assign div_start = launch_q && !div_busy;

	rir_div #(.W(NUMW)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.busy  (div_busy),
		.done  (div_done),
		.quo   (div_quo)
	);

	// bilinear sample positions
	always_comb begin
		oi  = CXW'(fx_q[PXW-1:FRACW]);
		oj  = CYW'(fy_q[PYW-1:FRACW]);
		oi2 = oi + CXW'(fx_q[FRACW-1:0] != '0);
		oj2 = oj + CYW'(fy_q[FRACW-1:0] != '0);
		ab  = shr_x_q ? '0 : fx_q[FRACW-1:0];
		ac  = shr_y_q ? '0 : fy_q[FRACW-1:0];
		need[SAMP_A] = 1'b1;
		need[SAMP_B] = ab != '0;
		need[SAMP_C] = ac != '0;
		need[SAMP_D] = (ab != '0) && (ac != '0);
	end

	// box window along each axis
	always_comb begin
		ex  = p2x_q[PXW-1:FRACW] - (PXW-FRACW)'(p2x_q[FRACW-1:0] == '0);
		ey  = p2y_q[PYW-1:FRACW] - (PYW-FRACW)'(p2y_q[FRACW-1:0] == '0);
		x0  = CXW'(p1x_q[PXW-1:FRACW]);
		y0  = CYW'(p1y_q[PYW-1:FRACW]);
		xl  = CXW'(ex) - x0;
		yl  = CYW'(ey) - y0;
		w1x = (xl == '0) ? ONE_FX : ONE_FX - WTW'(p1x_q[FRACW-1:0]);
		w1y = (yl == '0) ? ONE_FX : ONE_FX - WTW'(p1y_q[FRACW-1:0]);
		w2x = (p2x_q[FRACW-1:0] == '0) ? ONE_FX : WTW'(p2x_q[FRACW-1:0]);
		w2y = (p2y_q[FRACW-1:0] == '0) ? ONE_FX : WTW'(p2y_q[FRACW-1:0]);
		wx  = (u_q == '0) ? w1x : ((u_q == xl) ? w2x : ONE_FX);
		wy  = (v_q == '0) ? w1y : ((v_q == yl) ? w2y : ONE_FX);
		bx  = x0 + u_q;
		by  = y0 + v_q;
	end

	assign samp_issue = (state_q == ST_SAMP) && (samp_q < 3'(NUM_SAMP));
	assign box_issue  = (state_q == ST_BOX) && !box_done_q;

	// read address: bilinear samples or window walk
	always_comb begin
		if (state_q == ST_SAMP) begin
			case (samp_q[1:0])
				2'(SAMP_A): raddr = AW'(oj) * AW'(MAX_WIDTH) + AW'(oi);
				2'(SAMP_B): raddr = AW'(oj) * AW'(MAX_WIDTH) + AW'(oi2);
				2'(SAMP_C): raddr = AW'(oj2) * AW'(MAX_WIDTH) + AW'(oi);
				default:    raddr = AW'(oj2) * AW'(MAX_WIDTH) + AW'(oi2);
			endcase
		end else begin
			raddr = AW'(by) * AW'(MAX_WIDTH) + AW'(bx);
		end
	end

	rir_ram #(.WIDTH(PIXW), .DEPTH(DEPTH)) u_frame (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata({in_ch.in_red, in_ch.in_green, in_ch.in_blue}),
		.raddr(raddr),
		.rdata(rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			sel_q      <= '0;
			launch_q   <= 1'b0;
			samp_q     <= '0;
			samp_we_s1 <= '0;
			u_q        <= '0;
			v_q        <= '0;
			box_done_q <= 1'b0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			blend_q    <= 1'b0;
		end else begin
			if (div_start) begin
				launch_q <= 1'b0;
			end
			samp_we_s1 <= '0;
			if (samp_issue && need[samp_q[1:0]]) begin
				samp_we_s1[samp_q[1:0]] <= 1'b1;
			end
			v_s1 <= box_issue;
			v_s2 <= v_s1;
			case (state_q)
				ST_IDLE: begin
					if (cmp_acc) begin
						state_q  <= ST_DIV;
						sel_q    <= DSEL_FX;
						launch_q <= 1'b1;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						if ((sel_q == DSEL_FY && !shrink) || sel_q == DSEL_P2Y) begin
							state_q <= ST_SAMP;
							samp_q  <= '0;
						end else begin
							sel_q    <= sel_q + 1'b1;
							launch_q <= 1'b1;
						end
					end
				end
				ST_SAMP: begin
					samp_q <= samp_q + 1'b1;
					if (samp_q == 3'(NUM_SAMP)) begin
						if (shrink) begin
							state_q    <= ST_BOX;
							u_q        <= '0;
							v_q        <= '0;
							box_done_q <= 1'b0;
						end else begin
							state_q <= ST_BLEND;
							blend_q <= 1'b0;
						end
					end
				end
				ST_BOX: begin
					if (box_issue) begin
						if (u_q == xl) begin
							u_q <= '0;
							if (v_q == yl) begin
								box_done_q <= 1'b1;
							end else begin
								v_q <= v_q + 1'b1;
							end
						end else begin
							u_q <= u_q + 1'b1;
						end
					end else if (!v_s1 && !v_s2) begin
						state_q  <= ST_AVG;
						sel_q    <= DSEL_AVG0;
						launch_q <= 1'b1;
					end
				end
				ST_AVG: begin
					if (div_done) begin
						if (sel_q == DSEL_AVG2) begin
							state_q <= ST_BLEND;
							blend_q <= 1'b0;
						end else begin
							sel_q    <= sel_q + 1'b1;
							launch_q <= 1'b1;
						end
					end
				end
				ST_BLEND: begin
					blend_q <= 1'b1;
					if (blend_q) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item context, division results and window weights
	always_ff @(posedge clk) begin
		if (cmp_acc) begin
			px_q    <= in_ch.pos_x;
			py_q    <= in_ch.pos_y;
			i_q     <= i_in;
			j_q     <= j_in;
			shr_x_q <= dst_w_q < src_w_q;
			shr_y_q <= dst_h_q < src_h_q;
			tot_q   <= '0;
		end else if (v_s1) begin
			tot_q <= tot_q + TOTW'(w_s1);
		end
		if (div_done && state_q == ST_DIV) begin
			case (sel_q)
				DSEL_FX:  fx_q  <= PXW'(div_quo);
				DSEL_FY:  fy_q  <= PYW'(div_quo);
				DSEL_P1X: p1x_q <= PXW'(div_quo);
				DSEL_P2X: p2x_q <= PXW'(div_quo);
				DSEL_P1Y: p1y_q <= PYW'(div_quo);
				default:  p2y_q <= PYW'(div_quo);
			endcase
		end
		w_s1 <= WW'(wx) * WW'(wy);
	end

	// color lanes
	for (genvar l = 0; l < NUM_CH; l++) begin : g_lane
		always_comb begin
			lane_ctl[l].clr     = cmp_acc;
			lane_ctl[l].samp_we = samp_we_s1;
			lane_ctl[l].prod_en = v_s1;
			lane_ctl[l].acc_en  = v_s2;
			lane_ctl[l].avg_we  = div_done && (state_q == ST_AVG)
				&& (sel_q == DSEL_AVG0 + 4'(l));
		end

		rir_lane #(.ACCW(ACCW)) u_lane (
			.clk (clk),
			.ctl (lane_ctl[l]),
			.pix (rdata[PIXW-1-CHW*l -: CHW]),
			.w_s1(w_s1),
			.avg (div_quo[CHW-1:0]),
			.ab  (ab),
			.ac  (ac),
			.acc (lane_acc[l]),
			.res (lane_res[l])
		);
	end

	// merge lane results into the output register
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_x_q <= px_q;
			out_y_q <= py_q;
			out_r_q <= lane_res[0];
			out_g_q <= lane_res[1];
			out_b_q <= lane_res[2];
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.out_x     = out_x_q;
	assign out_ch.out_y     = out_y_q;
	assign out_ch.out_red   = out_r_q;
	assign out_ch.out_green = out_g_q;
	assign out_ch.out_blue  = out_b_q;

`ifndef ASSERT_OFF
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> div_busy)
		else $error("divider did not start");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV || state_q == ST_AVG))
		else $error("division finished outside a division step");
	a_box_drain: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> state_q == ST_BOX)
		else $error("window pipeline left before draining");
`endif

endmodule
`default_nettype wire

// File: tb/rgb_image_resampler_test.sv
`timescale 1ns / 100ps
module rgb_image_resampler_test;
	import rir_pkg::*;

	typedef struct {
		logic       command;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} pixel_item_t;

	typedef struct {
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_result_t;

	logic clk = 1'b0;
	logic arst_n;

	rir_in_if  in_ch();
	rir_out_if out_ch();
	rir_cfg_if cfg_ch();

	rgb_image_resampler dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_ch(cfg_ch)
	);

	always #5 clk = ~clk;

	pixel_item_t pending_items[$];
	rgb_result_t expected_pixels[$];
	int mismatches = 0;
	bit quiet = 1'b0;
	int send_gap = 0;
	int recv_stall = 0;

	// shadow of the source frame and of the size registers
	logic [23:0] frame_copy[65536];
	bit          frame_known[65536];
	int unsigned src_w = 1, src_h = 1, dst_w = 1, dst_h = 1;

	// feed items from the pending queue, with idle bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.command <= CMD_LOAD;
			in_ch.pos_x <= '0;
			in_ch.pos_y <= '0;
			in_ch.in_red <= '0;
			in_ch.in_green <= '0;
			in_ch.in_blue <= '0;
			send_gap <= 0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (send_gap > 0 && !quiet) begin
				in_ch.valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_items.size() > 0) begin
				in_ch.valid <= 1'b1;
				in_ch.command <= pending_items[0].command;
				in_ch.pos_x <= pending_items[0].x;
				in_ch.pos_y <= pending_items[0].y;
				in_ch.in_red <= pending_items[0].r;
				in_ch.in_green <= pending_items[0].g;
				in_ch.in_blue <= pending_items[0].b;
				void'(pending_items.pop_front());
				send_gap <= ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 12)) : 0;
			end else begin
				in_ch.valid <= 1'b0;
				send_gap <= 0;
			end
		end
	end

	// stall the result side in bursts and check each result item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			recv_stall <= 0;
		end else begin
			if (recv_stall > 0 && !quiet) begin
				out_ch.ready <= 1'b0;
				recv_stall <= recv_stall - 1;
			end else begin
				out_ch.ready <= 1'b1;
				recv_stall <= ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, 12)) : 0;
			end
			if (out_ch.valid && out_ch.ready) begin
				if (expected_pixels.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result item x=%0d y=%0d", out_ch.out_x,
							out_ch.out_y);
					mismatches <= mismatches + 1;
				end else begin
					if (out_ch.out_x !== expected_pixels[0].x
							|| out_ch.out_y !== expected_pixels[0].y
							|| out_ch.out_red !== expected_pixels[0].r
							|| out_ch.out_green !== expected_pixels[0].g
							|| out_ch.out_blue !== expected_pixels[0].b) begin
						if (mismatches < 10)
							$display("mismatch: expected (%0d,%0d) rgb %h %h %h, got (%0d,%0d) rgb %h %h %h",
								expected_pixels[0].x, expected_pixels[0].y,
								expected_pixels[0].r, expected_pixels[0].g,
								expected_pixels[0].b, out_ch.out_x, out_ch.out_y,
								out_ch.out_red, out_ch.out_green, out_ch.out_blue);
						mismatches <= mismatches + 1;
					end
					void'(expected_pixels.pop_front());
				end
			end
		end
	end

	function automatic int unsigned clamp_size(logic [8:0] v);
		if (v == 0)
			return 1;
		if (v > 256)
			return 256;
		return v;
	endfunction

	function automatic logic [63:0] lerp_pos(int unsigned src, int unsigned dst, int unsigned i);
		if (dst <= 1)
			return 0;
		return ((64'(src - 1) * i) << 16) / (dst - 1);
	endfunction

	task automatic window_axis(input int unsigned src, input int unsigned dst,
			input int unsigned i, output int unsigned first, output int unsigned span,
			output logic [63:0] w_lo, output logic [63:0] w_hi);
		logic [63:0] p1, p2;
		int unsigned s, e;
		p1 = ((64'(src) * i) << 16) / dst;
		p2 = ((64'(src) * (i + 1)) << 16) / dst;
		s = 32'(p1 >> 16);
		e = 32'(p2 >> 16);
		if (p2[15:0] == 0)
			e = e - 1;
		first = s;
		span = e - s;
		w_lo = 64'(ONE_FX) - p1[15:0];
		w_hi = p2 - (64'(e) << 16);
		if (span == 0)
			w_lo = 64'(ONE_FX);
	endtask

	task automatic queue_load(input logic [7:0] x, input logic [7:0] y, input logic [23:0] rgb);
		pixel_item_t it;
		it.command = CMD_LOAD;
		it.x = x;
		it.y = y;
		{it.r, it.g, it.b} = rgb;
		pending_items.push_back(it);
		frame_copy[{y, x}] = rgb;
		frame_known[{y, x}] = 1'b1;
	endtask

	// read a source pixel; load a random one first if it was never written
	task automatic read_source(input int unsigned x, input int unsigned y, output logic [23:0] rgb);
		if (!frame_known[{8'(y), 8'(x)}])
			queue_load(8'(x), 8'(y), 24'($urandom));
		rgb = frame_copy[{8'(y), 8'(x)}];
	endtask

	// predict one resampled pixel and queue the compute item behind any fill loads
	task automatic queue_compute(input logic [7:0] px, input logic [7:0] py);
		int unsigned i, j, oi, oj, oi2, oj2, x0, y0, xl, yl;
		logic [63:0] fx, fy, ab, ac, xw1, xw2, yw1, yw2, tot, wx, wy, w, top, bot, all;
		logic [63:0] sa[3], sb[3], sc[3], sd[3], acc[3];
		logic [23:0] p;
		pixel_item_t it;
		rgb_result_t res;
		i = (px < dst_w) ? px : dst_w - 1;
		j = (py < dst_h) ? py : dst_h - 1;
		fx = lerp_pos(src_w, dst_w, i);
		fy = lerp_pos(src_h, dst_h, j);
		oi = 32'(fx >> 16);
		oj = 32'(fy >> 16);
		oi2 = oi + (fx[15:0] != 0);
		oj2 = oj + (fy[15:0] != 0);
		ab = 0;
		ac = 0;
		tot = 0;
		for (int k = 0; k < 3; k++) begin
			sa[k] = 0; sb[k] = 0; sc[k] = 0; sd[k] = 0; acc[k] = 0;
		end
		if (dst_w >= src_w) begin
			ab = fx[15:0];
			read_source(oi, oj, p);
			for (int k = 0; k < 3; k++) sa[k] = p[16 - 8 * k +: 8];
			if (ab != 0) begin
				read_source(oi2, oj, p);
				for (int k = 0; k < 3; k++) sb[k] = p[16 - 8 * k +: 8];
			end
		end
		if (dst_h >= src_h) begin
			ac = fy[15:0];
			if (ac != 0) begin
				read_source(oi, oj2, p);
				for (int k = 0; k < 3; k++) sc[k] = p[16 - 8 * k +: 8];
				if (ab != 0) begin
					read_source(oi2, oj2, p);
					for (int k = 0; k < 3; k++) sd[k] = p[16 - 8 * k +: 8];
				end
			end
		end
		// box average over the covered window when either axis shrinks
		if (dst_w < src_w || dst_h < src_h) begin
			window_axis(src_w, dst_w, i, x0, xl, xw1, xw2);
			window_axis(src_h, dst_h, j, y0, yl, yw1, yw2);
			for (int v = 0; v <= yl; v++) begin
				wy = (v == 0) ? yw1 : ((v == yl) ? yw2 : 64'(ONE_FX));
				for (int u = 0; u <= xl; u++) begin
					wx = (u == 0) ? xw1 : ((u == xl) ? xw2 : 64'(ONE_FX));
					w = wy * wx;
					read_source(x0 + u, y0 + v, p);
					for (int k = 0; k < 3; k++) acc[k] += w * p[16 - 8 * k +: 8];
					tot += w;
				end
			end
			for (int k = 0; k < 3; k++)
				sa[k] = (tot != 0) ? (2 * acc[k] + tot - 1) / (2 * tot) : 0;
		end
		res.x = px;
		res.y = py;
		for (int k = 0; k < 3; k++) begin
			top = (64'(ONE_FX) - ab) * sa[k] + ab * sb[k];
			bot = (64'(ONE_FX) - ab) * sc[k] + ab * sd[k];
			all = (64'(ONE_FX) - ac) * top + ac * bot;
			if (k == 0) res.r = all[39:32];
			else if (k == 1) res.g = all[39:32];
			else res.b = all[39:32];
		end
		it.command = CMD_COMPUTE;
		it.x = px;
		it.y = py;
		it.r = 8'($urandom);
		it.g = 8'($urandom);
		it.b = 8'($urandom);
		pending_items.push_back(it);
		expected_pixels.push_back(res);
	endtask

	// write the four size registers, one accepted write each
	task automatic write_sizes(input logic [8:0] sw, input logic [8:0] sh,
			input logic [8:0] tw, input logic [8:0] th);
		logic [8:0] vals[4];
		logic [CFG_IDXW-1:0] idx[4];
		vals = '{sw, sh, tw, th};
		idx = '{REG_SRC_W, REG_SRC_H, REG_DST_W, REG_DST_H};
		@(posedge clk);
		for (int n = 0; n < 4; n++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= idx[n];
			cfg_ch.data <= vals[n];
			do @(posedge clk); while (!cfg_ch.ready);
		end
		cfg_ch.valid <= 1'b0;
		src_w = clamp_size(sw);
		src_h = clamp_size(sh);
		dst_w = clamp_size(tw);
		dst_h = clamp_size(th);
	endtask

	// hold until the block has drained, then let trailing loads settle
	task automatic wait_drained();
		do @(posedge clk);
		while (pending_items.size() != 0 || expected_pixels.size() != 0 || in_ch.valid);
		repeat (50) @(posedge clk);
	endtask

	// pick a size pair for one axis: magnify, or shrink by at most eight
	task automatic pick_axis(output int unsigned src, output int unsigned dst);
		src = $urandom_range(1, 256);
		if ($urandom_range(0, 1) == 0)
			dst = $urandom_range(src, 256);
		else
			dst = $urandom_range((src + 7) / 8, src);
	endtask

	task automatic random_phase(input int count);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 9) < 6) begin
				if ($urandom_range(0, 4) == 0)
					queue_compute(8'($urandom), 8'($urandom));
				else
					queue_compute(8'($urandom_range(0, dst_w - 1)),
						8'($urandom_range(0, dst_h - 1)));
			end else begin
				if ($urandom_range(0, 4) == 0)
					queue_load(8'($urandom), 8'($urandom), 24'($urandom));
				else
					queue_load(8'($urandom_range(0, src_w - 1)),
						8'($urandom_range(0, src_h - 1)), 24'($urandom));
			end
		end
	endtask

	initial begin
		int unsigned sw, sh, tw, th;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_SRC_W;
		cfg_ch.data = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset sizes: a one-pixel frame, computes inside and outside the target
		queue_load(8'd0, 8'd0, 24'hFFFFFF);
		queue_compute(8'd0, 8'd0);
		queue_compute(8'd255, 8'd255);
		queue_load(8'd255, 8'd255, 24'h000000);
		queue_load(8'd0, 8'd0, 24'h000000);
		queue_compute(8'd0, 8'd255);
		wait_drained();

		// one source pixel stretched over the largest target
		write_sizes(9'd1, 9'd1, 9'd256, 9'd256);
		queue_load(8'd0, 8'd0, 24'hA5F00F);
		queue_compute(8'd255, 8'd0);
		queue_compute(8'd128, 8'd77);
		wait_drained();

		// full size on both sides
		write_sizes(9'd256, 9'd256, 9'd256, 9'd256);
		queue_compute(8'd255, 8'd255);
		queue_compute(8'd0, 8'd0);
		queue_compute(8'd17, 8'd200);
		wait_drained();

		// out of range registers, shrinking to one row and one column
		write_sizes(9'd0, 9'd511, 9'd5, 9'd511);
		queue_compute(8'd4, 8'd255);
		wait_drained();
		write_sizes(9'd256, 9'd2, 9'd1, 9'd1);
		queue_compute(8'd0, 8'd0);
		queue_compute(8'd200, 8'd9);
		wait_drained();
		write_sizes(9'd3, 9'd7, 9'd2, 9'd256);
		queue_compute(8'd1, 8'd100);
		queue_compute(8'd255, 8'd0);
		wait_drained();

		// random sizes and random items
		for (int ph = 0; ph < 9; ph++) begin
			pick_axis(sw, tw);
			pick_axis(sh, th);
			write_sizes(9'(sw), 9'(sh), 9'(tw), 9'(th));
			if (ph == 8)
				quiet = 1'b1;
			random_phase(170);
			wait_drained();
		end

		repeat (1000) @(posedge clk);
		if (mismatches == 0 && expected_pixels.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#50000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
